FILE: src/qau_pkg.sv
// qau_pkg: operation codes, status codes, classes and queue sizing shared by the
// quaternion arithmetic unit. Depends on nothing.
package qau_pkg;

    typedef logic [2:0] t_op;
    localparam t_op OP_PRODUCT   = 3'd0;
    localparam t_op OP_DOT       = 3'd1;
    localparam t_op OP_NEGATE    = 3'd2;
    localparam t_op OP_LENGTH    = 3'd3;
    localparam t_op OP_NORMALIZE = 3'd4;
    localparam t_op OP_MATRIX    = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_SAT  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    // execution class picked by the front end
    typedef enum logic [1:0] {
        CL_MUL  = 2'd0,
        CL_NEG  = 2'd1,
        CL_ROOT = 2'd2,
        CL_NONE = 2'd3
    } t_cls;

    typedef struct packed {
        t_op  op;
        t_cls cls;
    } t_tag;

    localparam int QDEPTH = 4;
    localparam int QPTRW  = $clog2(QDEPTH);

    // operand pairs of the 16 product slots, component 0 = w .. 3 = z
    localparam int NPROD = 16;
    localparam int PA [NPROD] = '{0, 1, 2, 3, 0, 1, 3, 2, 0, 2, 1, 3, 0, 3, 2, 1};
    localparam int PB [NPROD] = '{0, 1, 2, 3, 1, 0, 2, 3, 2, 0, 3, 1, 3, 0, 1, 2};

    function automatic t_cls classify(t_op op);
        t_cls c;
        unique case (op)
            OP_PRODUCT, OP_DOT, OP_MATRIX: c = CL_MUL;
            OP_NEGATE:                     c = CL_NEG;
            OP_LENGTH, OP_NORMALIZE:       c = CL_ROOT;
            default:                       c = CL_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: src/quaternion_arithmetic_unit.sv
// quaternion_arithmetic_unit: top level; input queue (qau_front) feeding the
// execution side (qau_back, qau_root). Depends on qau_pkg, qau_front, qau_back.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   request | i_valid / o_ready  | i_req_type, i_a_w..i_a_z, i_b_w..i_b_z
//   result  | o_valid / i_ready  | o_res_0..o_res_3, o_row_index, o_is_last, o_status
//
// Product, dot, negate and unused codes: one result word per cycle while the result side
//   takes them; queue head -> product slots (registered) -> sum/round -> output register.
// Matrix conversion: three result words, one row per cycle while the result side takes them.
// Length: digit-by-digit square root (one square root digit a cycle); normalize
//   then divides each of the four components in turn with the restoring divider.
// Synchronous active-low reset clears the queue and the valid flags; no sweep.
// A 4-word queue keeps the request side open while the result side stalls.
module quaternion_arithmetic_unit #(
    parameter int COMP_WIDTH = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_req_type,
    input  logic [COMP_WIDTH-1:0] i_a_w,
    input  logic [COMP_WIDTH-1:0] i_a_x,
    input  logic [COMP_WIDTH-1:0] i_a_y,
    input  logic [COMP_WIDTH-1:0] i_a_z,
    input  logic [COMP_WIDTH-1:0] i_b_w,
    input  logic [COMP_WIDTH-1:0] i_b_x,
    input  logic [COMP_WIDTH-1:0] i_b_y,
    input  logic [COMP_WIDTH-1:0] i_b_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COMP_WIDTH-1:0] o_res_0,
    output logic [COMP_WIDTH-1:0] o_res_1,
    output logic [COMP_WIDTH-1:0] o_res_2,
    output logic [COMP_WIDTH-1:0] o_res_3,
    output logic [1:0]            o_row_index,
    output logic                  o_is_last,
    output logic [1:0]            o_status
);
    import qau_pkg::*;

    logic [3:0][COMP_WIDTH-1:0] a_vec, b_vec;
    logic                       head_valid, pop;
    t_tag                       head_tag;
    logic [3:0][COMP_WIDTH-1:0] head_a, head_b;
    logic [3:0][COMP_WIDTH-1:0] res;

    // component 0 = w
    assign a_vec = {i_a_z, i_a_y, i_a_x, i_a_w};
    assign b_vec = {i_b_z, i_b_y, i_b_x, i_b_w};

    qau_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_req_type),
        .i_a          (a_vec),
        .i_b          (b_vec),
        .o_head_valid (head_valid),
        .o_head_tag   (head_tag),
        .o_head_a     (head_a),
        .o_head_b     (head_b),
        .i_pop        (pop)
    );

    qau_back #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_tag   (head_tag),
        .i_head_a     (head_a),
        .i_head_b     (head_b),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_res        (res),
        .o_row_index  (o_row_index),
        .o_is_last    (o_is_last),
        .o_status     (o_status)
    );

    assign o_res_0 = res[0];
    assign o_res_1 = res[1];
    assign o_res_2 = res[2];
    assign o_res_3 = res[3];

endmodule

FILE: src/qau_front.sv
// qau_front: input queue of the quaternion unit; classifies each word on entry.
// Depends on qau_pkg.
module qau_front #(
    parameter int COMP_WIDTH = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  qau_pkg::t_op                  i_op,
    input  logic [3:0][COMP_WIDTH-1:0]    i_a,
    input  logic [3:0][COMP_WIDTH-1:0]    i_b,
    output logic                          o_head_valid,
    output qau_pkg::t_tag                 o_head_tag,
    output logic [3:0][COMP_WIDTH-1:0]    o_head_a,
    output logic [3:0][COMP_WIDTH-1:0]    o_head_b,
    input  logic                          i_pop
);
    import qau_pkg::*;

    t_tag                       r_tag [QDEPTH];
    logic [3:0][COMP_WIDTH-1:0] r_a   [QDEPTH];
    logic [3:0][COMP_WIDTH-1:0] r_b   [QDEPTH];
    logic [QPTRW-1:0]           r_wr, n_wr, r_rd, n_rd;
    logic [QPTRW:0]             r_cnt, n_cnt;
    logic                       push, pop;
    t_tag                       tag_in;

    assign o_ready      = (r_cnt != (QPTRW+1)'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && o_head_valid;

    assign tag_in.op  = i_op;
    assign tag_in.cls = classify(i_op);

    assign o_head_tag = r_tag[r_rd];
    assign o_head_a   = r_a[r_rd];
    assign o_head_b   = r_b[r_rd];

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QPTRW+1)'(push) - (QPTRW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // matrix conversion squares A, so B is replaced by A here
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_tag[r_wr] <= tag_in;
            r_a[r_wr]   <= i_a;
            r_b[r_wr]   <= (i_op == OP_MATRIX) ? i_a : i_b;
        end
    end

endmodule

FILE: src/qau_root.sv
// qau_root: iterative length / normalize unit (digit-by-digit square root, then
// restoring division per component). Depends on qau_pkg.
module qau_root #(
    parameter int COMP_WIDTH = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_norm,
    input  logic [3:0][COMP_WIDTH-1:0]    i_a,
    input  logic                          i_ack,
    output logic                          o_done,
    output logic [3:0][COMP_WIDTH-1:0]    o_res,
    output qau_pkg::t_status              o_status
);
    import qau_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int SW   = 2*CW + 2;
    localparam int SQ   = SW / 2;
    localparam int RW   = CW + 1;
    localparam int NW   = CW + FRAC_BITS + 1;
    localparam int MAXN = (NW > SQ) ? NW : SQ;
    localparam int CNTW = $clog2(MAXN + 1);
    localparam logic [SW-1:0] SMAX = (SW > 64) ? SW'({2'b00, {64{1'b1}}}) : '1;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [NW-1:0] QMAX = (NW'(1) << (CW-1)) - NW'(1);
    localparam logic [RW-1:0] LMAX = (RW'(1) << (CW-1)) - RW'(1);

    typedef enum logic [4:0] {
        R_IDLE = 5'b00001,
        R_SUM  = 5'b00010,
        R_SQRT = 5'b00100,
        R_DIV  = 5'b01000,
        R_DONE = 5'b10000
    } t_rstate;

    t_rstate                    r_state;
    logic                       r_norm;
    logic [3:0][CW-1:0]         r_a;
    logic [2*CW-1:0]            r_sq [4];
    logic [SW-1:0]              r_s;
    logic [RW-1:0]              r_root;
    logic [RW+1:0]              r_rem;
    logic [CNTW-1:0]            r_cnt;
    logic [RW-1:0]              r_len;
    logic [NW-1:0]              r_num;
    logic [NW-1:0]              r_q;
    logic [RW-1:0]              r_drem;
    logic [1:0]                 r_comp;
    logic [3:0][CW-1:0]         r_res;
    t_status                    r_status;
    logic                       r_sat;

    logic [SW-1:0]              sum, sum_c;
    logic [RW+3:0]              rem2, trial;
    logic                       sq_ge;
    logic [RW+1:0]              n_rem;
    logic [RW-1:0]              n_root, len_c;
    logic [RW:0]                drem2;
    logic                       dv_ge;
    logic [RW-1:0]              n_drem;
    logic [NW-1:0]              n_q;
    logic [CW-1:0]              qv;
    logic                       qsat;
    logic                       start_ok;

    function automatic logic [2*CW-1:0] square(logic [CW-1:0] v);
        logic signed [2*CW-1:0] e;
        e = (2*CW)'(signed'(v));
        return e * e;
    endfunction

    function automatic logic [NW-1:0] numer(logic [CW-1:0] v, logic [RW-1:0] l);
        logic [CW-1:0] m;
        m = v[CW-1] ? -v : v;
        return (NW'(m) << FRAC_BITS) + NW'(l >> 1);
    endfunction

    assign o_done   = (r_state == R_DONE);
    assign o_res    = r_res;
    assign o_status = r_status;
    assign start_ok = i_start && ((r_state == R_IDLE) || ((r_state == R_DONE) && i_ack));

    always_comb begin
        sum   = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]) + SW'(r_sq[3]);
        sum_c = (sum > SMAX) ? SMAX : sum;
        // square root step: two bits of the radicand a cycle
        rem2   = {r_rem, r_s[SW-1:SW-2]};
        trial  = {2'b00, r_root, 2'b01};
        sq_ge  = (rem2 >= trial);
        n_rem  = sq_ge ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
        n_root = {r_root[RW-2:0], sq_ge};
        len_c  = n_root + RW'(n_rem > {2'b00, n_root});
        // division step: one quotient bit a cycle
        drem2  = {r_drem, r_num[NW-1]};
        dv_ge  = (drem2 >= {1'b0, r_len});
        n_drem = dv_ge ? RW'(drem2 - {1'b0, r_len}) : RW'(drem2);
        n_q    = {r_q[NW-2:0], dv_ge};
        qsat   = 1'b0;
        if (!r_a[r_comp][CW-1]) begin
            if (n_q > QMAX) begin
                qv   = CMAX;
                qsat = 1'b1;
            end else begin
                qv = CW'(n_q);
            end
        end else begin
            if (n_q > QMAX + NW'(1)) begin
                qv   = CMIN;
                qsat = 1'b1;
            end else begin
                qv = CW'(-n_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            unique case (r_state)
                R_IDLE: begin
                    if (start_ok) r_state <= R_SUM;
                end
                R_SUM: begin
                    r_state <= (sum == '0) ? R_DONE : R_SQRT;
                end
                R_SQRT: begin
                    if (r_cnt == CNTW'(SQ-1)) r_state <= r_norm ? R_DIV : R_DONE;
                end
                R_DIV: begin
                    if ((r_cnt == CNTW'(NW-1)) && (r_comp == 2'd3)) r_state <= R_DONE;
                end
                R_DONE: begin
                    if (i_ack) r_state <= start_ok ? R_SUM : R_IDLE;
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_ok) begin
            r_a    <= i_a;
            r_norm <= i_norm;
            for (int k = 0; k < 4; k++) r_sq[k] <= square(i_a[k]);
        end
        unique case (r_state)
            R_SUM: begin
                r_s    <= sum_c;
                r_root <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_sat  <= 1'b0;
                if (sum == '0) begin
                    // A is all zero: length is a plain zero, normalize flags it
                    r_res    <= r_a;
                    r_status <= r_norm ? ST_ZERO : ST_OK;
                end
            end
            R_SQRT: begin
                r_s    <= r_s << 2;
                r_root <= n_root;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(SQ-1)) begin
                    r_len  <= len_c;
                    r_comp <= 2'd0;
                    r_num  <= numer(r_a[0], len_c);
                    r_q    <= '0;
                    r_drem <= '0;
                    r_cnt  <= '0;
                    if (!r_norm) begin
                        r_res[3:1] <= '0;
                        if (len_c > LMAX) begin
                            r_res[0] <= CMAX;
                            r_status <= ST_SAT;
                        end else begin
                            r_res[0] <= CW'(len_c);
                            r_status <= ST_OK;
                        end
                    end
                end
            end
            R_DIV: begin
                r_num  <= r_num << 1;
                r_q    <= n_q;
                r_drem <= n_drem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW-1)) begin
                    r_res[r_comp] <= qv;
                    r_sat         <= r_sat | qsat;
                    r_comp        <= r_comp + 1'b1;
                    r_num         <= numer(r_a[r_comp + 1'b1], r_len);
                    r_q           <= '0;
                    r_drem        <= '0;
                    r_cnt         <= '0;
                    if (r_comp == 2'd3) r_status <= (r_sat | qsat) ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: src/qau_back.sv
// qau_back: execution side of the quaternion unit: product slots, sum/round/
// saturate, matrix row sequencing and the output register. Depends on qau_pkg, qau_root.
module qau_back #(
    parameter int COMP_WIDTH = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  qau_pkg::t_tag                 i_head_tag,
    input  logic [3:0][COMP_WIDTH-1:0]    i_head_a,
    input  logic [3:0][COMP_WIDTH-1:0]    i_head_b,
    output logic                          o_pop,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [3:0][COMP_WIDTH-1:0]    o_res,
    output logic [1:0]                    o_row_index,
    output logic                          o_is_last,
    output qau_pkg::t_status              o_status
);
    import qau_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int PW   = 2*CW;
    localparam int BASEW = (2*FRAC_BITS + 2 > PW) ? 2*FRAC_BITS + 2 : PW;
    localparam int SUMW = BASEW + 3;
    localparam logic signed [SUMW-1:0] HALF  = SUMW'(1) << (FRAC_BITS-1);
    localparam logic signed [SUMW-1:0] ONE   = SUMW'(1) << (2*FRAC_BITS);
    localparam logic signed [SUMW-1:0] CMAXS = (SUMW'(1) << (CW-1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] CMINS = -CMAXS - SUMW'(1);
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [PW-1:0]   r_p [NPROD];
    logic                   r_s1_valid;
    t_tag                   r_s1_tag;
    logic [3:0][CW-1:0]     r_s1_a;
    logic [1:0]             r_row;
    logic                   r_out_valid;
    logic [3:0][CW-1:0]     r_res;
    logic [1:0]             r_row_out;
    logic                   r_last;
    t_status                r_status;

    logic                   out_free, s1_done, s1_load, out_load;
    logic                   root_done;
    logic [3:0][CW-1:0]     root_res;
    t_status                root_status;
    logic signed [SUMW-1:0] s [4];
    logic signed [SUMW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic [CW:0]            rs [4];
    logic [3:0]             used;
    logic [3:0][CW-1:0]     n_res;
    logic [1:0]             n_row_out;
    logic                   n_last;
    t_status                n_status;
    logic                   any_sat;

    function automatic logic signed [PW-1:0] mul(logic [CW-1:0] a, logic [CW-1:0] b);
        return PW'(signed'(a)) * PW'(signed'(b));
    endfunction

    function automatic logic signed [SUMW-1:0] ext(logic signed [PW-1:0] p);
        return SUMW'(p);
    endfunction

    // round half up to FRAC_BITS fraction bits, then saturate; msb is the flag
    function automatic logic [CW:0] rnd(logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] q;
        q = (v + HALF) >>> FRAC_BITS;
        if (q > CMAXS)      return {1'b1, CMAX};
        else if (q < CMINS) return {1'b1, CMIN};
        else                return {1'b0, CW'(q)};
    endfunction

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        s1_done = 1'b0;
        if (r_s1_valid && out_free) begin
            if (r_s1_tag.cls == CL_ROOT)
                s1_done = root_done;
            else if (r_s1_tag.op == OP_MATRIX)
                s1_done = (r_row == ROW_LAST);
            else
                s1_done = 1'b1;
        end
    end

    assign s1_load  = i_head_valid && (!r_s1_valid || s1_done);
    assign o_pop    = s1_load;
    assign out_load = r_s1_valid && out_free && ((r_s1_tag.cls != CL_ROOT) || root_done);

    qau_root #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s1_load && (i_head_tag.cls == CL_ROOT)),
        .i_norm   (i_head_tag.op == OP_NORMALIZE),
        .i_a      (i_head_a),
        .i_ack    (s1_done && (r_s1_tag.cls == CL_ROOT)),
        .o_done   (root_done),
        .o_res    (root_res),
        .o_status (root_status)
    );

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_tag <= i_head_tag;
            r_s1_a   <= i_head_a;
            for (int k = 0; k < NPROD; k++) r_p[k] <= mul(i_head_a[PA[k]], i_head_b[PB[k]]);
        end
    end

    // sums of products; for matrix B = A so the slots hold the squares and cross terms
    always_comb begin
        xx = ext(r_p[1]);  yy = ext(r_p[2]);  zz = ext(r_p[3]);
        wx = ext(r_p[4]);  wy = ext(r_p[8]);  wz = ext(r_p[12]);
        xz = ext(r_p[10]); yz = ext(r_p[7]);  xy = ext(r_p[14]);
        for (int k = 0; k < 4; k++) s[k] = '0;
        used = 4'b0000;
        if (r_s1_tag.op == OP_MATRIX) begin
            used = 4'b0111;
            priority case (r_row)
                ROW_FIRST: begin
                    s[0] = ONE - ((yy + zz) <<< 1);
                    s[1] = (xy + wz) <<< 1;
                    s[2] = (xz - wy) <<< 1;
                end
                2'd1: begin
                    s[0] = (xy - wz) <<< 1;
                    s[1] = ONE - ((xx + zz) <<< 1);
                    s[2] = (yz + wx) <<< 1;
                end
                default: begin
                    s[0] = (xz + wy) <<< 1;
                    s[1] = (yz - wx) <<< 1;
                    s[2] = ONE - ((xx + yy) <<< 1);
                end
            endcase
        end else if (r_s1_tag.op == OP_DOT) begin
            used = 4'b0001;
            s[0] = ext(r_p[0]) + xx + yy + zz;
        end else begin
            used = 4'b1111;
            s[0] = ext(r_p[0]) - ext(r_p[1]) - ext(r_p[2]) - ext(r_p[3]);
            s[1] = ext(r_p[4]) + ext(r_p[5]) + ext(r_p[6]) - ext(r_p[7]);
            s[2] = ext(r_p[8]) + ext(r_p[9]) + ext(r_p[10]) - ext(r_p[11]);
            s[3] = ext(r_p[12]) + ext(r_p[13]) + ext(r_p[14]) - ext(r_p[15]);
        end
        for (int k = 0; k < 4; k++) rs[k] = rnd(s[k]);
    end

    always_comb begin
        n_res     = '0;
        n_row_out = ROW_FIRST;
        n_last    = 1'b1;
        n_status  = ST_OK;
        any_sat   = 1'b0;
        unique case (r_s1_tag.cls)
            CL_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    if (used[k]) begin
                        n_res[k] = rs[k][CW-1:0];
                        any_sat  = any_sat | rs[k][CW];
                    end
                end
                if (r_s1_tag.op == OP_MATRIX) begin
                    n_row_out = r_row;
                    n_last    = (r_row == ROW_LAST);
                end
                n_status = any_sat ? ST_SAT : ST_OK;
            end
            CL_NEG: begin
                for (int k = 0; k < 4; k++) begin
                    if (r_s1_a[k] == CMIN) begin
                        n_res[k] = CMAX;
                        any_sat  = 1'b1;
                    end else begin
                        n_res[k] = -r_s1_a[k];
                    end
                end
                n_status = any_sat ? ST_SAT : ST_OK;
            end
            CL_ROOT: begin
                n_res    = root_res;
                n_status = root_status;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= ROW_FIRST;
        end else begin
            if (s1_load)      r_s1_valid <= 1'b1;
            else if (s1_done) r_s1_valid <= 1'b0;
            if (out_load)     r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (out_load && (r_s1_tag.cls == CL_MUL) && (r_s1_tag.op == OP_MATRIX))
                r_row <= (r_row == ROW_LAST) ? ROW_FIRST : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res     <= n_res;
            r_row_out <= n_row_out;
            r_last    <= n_last;
            r_status  <= n_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_res       = r_res;
    assign o_row_index = r_row_out;
    assign o_is_last   = r_last;
    assign o_status    = r_status;

endmodule

FILE: src/qau_checker.sv
// qau_checker: port-level assertions for quaternion_arithmetic_unit, with bind.
// Depends on the top level's ports only.
module qau_checker #(
    parameter int COMP_WIDTH = 18
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [COMP_WIDTH-1:0] o_res_0,
    input logic [COMP_WIDTH-1:0] o_res_1,
    input logic [COMP_WIDTH-1:0] o_res_2,
    input logic [COMP_WIDTH-1:0] o_res_3,
    input logic [1:0]            o_row_index,
    input logic                  o_is_last,
    input logic [1:0]            o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_0) && $stable(o_status)
            && $stable(o_is_last) && $stable(o_row_index))
        else $error("result word changed while stalled");

    a_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_row_index != 2'd0) |-> (o_is_last == (o_row_index == 2'd2)))
        else $error("matrix row and last flag disagree");

    a_row_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_is_last |=>
            o_valid && (o_row_index == $past(o_row_index) + 2'd1))
        else $error("matrix rows not back to back");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == 2'd2) |-> o_is_last && (o_row_index == 2'd0)
            && (o_res_0 == '0) && (o_res_1 == '0) && (o_res_2 == '0) && (o_res_3 == '0))
        else $error("zero-length result not all zero");

endmodule

bind quaternion_arithmetic_unit qau_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qau_checker (.*);

FILE: verif/tb_quaternion_arithmetic_unit.sv
// tb_quaternion_arithmetic_unit: self-checking bench for the quaternion unit,
// with a bit-exact predictor, directed table and random phases. Depends on qau_pkg.
module tb_quaternion_arithmetic_unit;
    import qau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW   = 18;
    localparam int FB   = 16;
    localparam longint CMAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint ONE  = longint'(1) <<< FB;
    localparam t_op OP_UNUSED6 = 3'd6;
    localparam t_op OP_UNUSED7 = 3'd7;

    typedef logic signed [CW-1:0] t_comp;

    // one result word as the block should deliver it
    typedef struct {
        t_comp   res [4];
        logic [1:0] row;
        logic    last;
        t_status st;
    } t_word;

    // directed row: operands plus an optional hand-typed single result
    typedef struct {
        t_op    op;
        longint a [4];
        longint b [4];
        bit     typed;
        longint r0;
        t_status st;
    } t_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic [2:0]      i_req_type;
    logic [CW-1:0]   i_a_w, i_a_x, i_a_y, i_a_z;
    logic [CW-1:0]   i_b_w, i_b_x, i_b_y, i_b_z;
    logic            o_valid;
    logic            i_ready;
    logic [CW-1:0]   o_res_0, o_res_1, o_res_2, o_res_3;
    logic [1:0]      o_row_index;
    logic            o_is_last;
    logic [1:0]      o_status;

    t_word expected_words [$];
    int    err_cnt;
    int    idle_pct;      // sender idles this share of cycles
    int    stall_pct;     // receiver stalls this share of cycles
    bit    hold_req;      // ask the receiver for a long hold-off
    int    hold_left;

    quaternion_arithmetic_unit #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // safety net: far beyond the slowest run (normalize, stalls)
    initial begin
        #20ms;
        $display("tb_quaternion_arithmetic_unit NOT OK");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // ---------------- predictor ----------------
    // round the exact sum (2*FB fraction bits) half up, then clamp
    function automatic longint clamp(input longint v, inout bit sat);
        if (v > CMAX) begin sat = 1; return CMAX; end
        if (v < CMIN) begin sat = 1; return CMIN; end
        return v;
    endfunction

    function automatic longint rnd(input longint s, inout bit sat);
        return clamp((s + (longint'(1) <<< (FB - 1))) >>> FB, sat);
    endfunction

    function automatic longint unsigned root_nearest(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (s > r) r++;
        return r;
    endfunction

    function automatic t_word mk(input longint r [4], input int row, input bit last,
                                 input t_status st);
        t_word wd;
        for (int i = 0; i < 4; i++) wd.res[i] = t_comp'(r[i]);
        wd.row  = row[1:0];
        wd.last = last;
        wd.st   = st;
        return wd;
    endfunction

    // works out every result word one request causes and queues them
    task automatic predict_quat_op(input t_op op, input longint a [4], input longint b [4]);
        longint r [4];
        longint m [4];
        longint w, x, y, z;
        longint s [9];
        longint unsigned sq, len, mag, q;
        bit sat, rs;
        r = '{0, 0, 0, 0};
        sat = 0;
        w = a[0]; x = a[1]; y = a[2]; z = a[3];
        case (op)
            OP_PRODUCT: begin
                r[0] = rnd(w*b[0] - x*b[1] - y*b[2] - z*b[3], sat);
                r[1] = rnd(w*b[1] + x*b[0] + z*b[2] - y*b[3], sat);
                r[2] = rnd(w*b[2] + y*b[0] + x*b[3] - z*b[1], sat);
                r[3] = rnd(w*b[3] + z*b[0] + y*b[1] - x*b[2], sat);
            end
            OP_DOT:    r[0] = rnd(w*b[0] + x*b[1] + y*b[2] + z*b[3], sat);
            OP_NEGATE: for (int i = 0; i < 4; i++) r[i] = clamp(-a[i], sat);
            OP_LENGTH, OP_NORMALIZE: begin
                sq  = w*w + x*x + y*y + z*z;
                len = root_nearest(sq);
                if (op == OP_LENGTH) begin
                    r[0] = clamp(longint'(len), sat);
                end else if (sq == 0) begin
                    // zero length: A comes back unchanged, flagged
                    expected_words.push_back(mk(a, 0, 1, ST_ZERO));
                    return;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        mag = (a[i] < 0) ? -a[i] : a[i];
                        q = ((mag << FB) + (len >> 1)) / len;
                        r[i] = clamp((a[i] < 0) ? -longint'(q) : longint'(q), sat);
                    end
                end
            end
            OP_MATRIX: begin
                s[0] = (ONE <<< FB) - 2*y*y - 2*z*z;
                s[1] = 2*x*y + 2*w*z;
                s[2] = 2*x*z - 2*w*y;
                s[3] = 2*x*y - 2*w*z;
                s[4] = (ONE <<< FB) - 2*x*x - 2*z*z;
                s[5] = 2*y*z + 2*w*x;
                s[6] = 2*x*z + 2*w*y;
                s[7] = 2*y*z - 2*w*x;
                s[8] = (ONE <<< FB) - 2*x*x - 2*y*y;
                for (int row = 0; row < 3; row++) begin
                    rs = 0;
                    for (int c = 0; c < 3; c++) m[c] = rnd(s[row*3 + c], rs);
                    m[3] = 0;
                    expected_words.push_back(mk(m, row, row == 2, rs ? ST_SAT : ST_OK));
                end
                return;
            end
            default: ;  // unused codes: one all-zero word
        endcase
        expected_words.push_back(mk(r, 0, 1, sat ? ST_SAT : ST_OK));
    endtask

    // ---------------- request side ----------------
    // offers one word and holds it until accepted; idles first at random
    task automatic send_req(input t_op op, input longint a [4], input longint b [4],
                            input bit typed = 0, input longint r0 = 0,
                            input t_status st = ST_OK);
        longint r [4];
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_req_type = op;
        {i_a_w, i_a_x, i_a_y, i_a_z} = {a[0][CW-1:0], a[1][CW-1:0], a[2][CW-1:0], a[3][CW-1:0]};
        {i_b_w, i_b_x, i_b_y, i_b_z} = {b[0][CW-1:0], b[1][CW-1:0], b[2][CW-1:0], b[3][CW-1:0]};
        do @(posedge i_clk); while (!o_ready);
        if (typed) begin
            r = '{r0, 0, 0, 0};
            if (op == OP_NORMALIZE) r = a;
            expected_words.push_back(mk(r, 0, 1, st));
        end else begin
            predict_quat_op(op, a, b);
        end
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // random component: full range, near one, tiny or an extreme
    function automatic longint rand_comp();
        case ($urandom_range(0, 5))
            0, 1:    return longint'($signed(18'($urandom)));
            2:       return longint'($urandom_range(0, 2*ONE)) - ONE;
            3:       return longint'($urandom_range(0, 64)) - 32;
            4:       return ($urandom_range(0, 1)) ? CMAX : CMIN;
            default: return longint'($urandom_range(0, ONE)) - ONE/2;
        endcase
    endfunction

    task automatic send_random(input int n);
        longint a [4], b [4];
        t_op op;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 4; i++) begin
                a[i] = rand_comp();
                b[i] = rand_comp();
            end
            // mostly real operations, an unused code now and then
            op = ($urandom_range(0, 15) == 0) ? t_op'($urandom_range(6, 7))
                                              : t_op'($urandom_range(0, 5));
            send_req(op, a, b);
        end
    endtask

    // ---------------- result side ----------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_word got, exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            got.res  = '{t_comp'(o_res_0), t_comp'(o_res_1), t_comp'(o_res_2),
                         t_comp'(o_res_3)};
            got.row  = o_row_index;
            got.last = o_is_last;
            got.st   = o_status;
            if (expected_words.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                exp_w = expected_words.pop_front();
                for (int i = 0; i < 4; i++)
                    if (got.res[i] !== exp_w.res[i])
                        report($sformatf("res_%0d got %0d want %0d", i, got.res[i],
                                         exp_w.res[i]));
                if (got.row !== exp_w.row)
                    report($sformatf("row_index got %0d want %0d", got.row, exp_w.row));
                if (got.last !== exp_w.last)
                    report($sformatf("is_last got %0b want %0b", got.last, exp_w.last));
                if (got.st !== exp_w.st)
                    report($sformatf("status got %0d want %0d", got.st, exp_w.st));
            end
        end
    end

    // ---------------- directed table ----------------
    t_row dir_rows [] = '{
        // identity times B gives B
        '{OP_PRODUCT,   '{ONE, 0, 0, 0}, '{1, -2, 3, -4}, 0, 0, ST_OK},
        '{OP_PRODUCT,   '{CMAX, CMAX, CMAX, CMAX}, '{CMAX, CMIN, CMAX, CMIN}, 0, 0, ST_OK},
        '{OP_PRODUCT,   '{CMIN, CMIN, CMIN, CMIN}, '{CMIN, CMIN, CMIN, CMIN}, 0, 0, ST_OK},
        '{OP_DOT,       '{0, 0, 0, 0}, '{CMAX, CMIN, 1, -1}, 1, 0, ST_OK},
        '{OP_DOT,       '{CMAX, CMAX, CMAX, CMAX}, '{CMAX, CMAX, CMAX, CMAX}, 0, 0, ST_OK},
        '{OP_DOT,       '{CMIN, 1, -1, 3}, '{CMAX, 1, 1, 5}, 0, 0, ST_OK},
        // negating the most negative value clamps and flags
        '{OP_NEGATE,    '{CMIN, 0, 0, 0}, '{0, 0, 0, 0}, 1, CMAX, ST_SAT},
        '{OP_NEGATE,    '{CMAX, -1, 1, CMIN}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_LENGTH,    '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1, 0, ST_OK},
        '{OP_LENGTH,    '{ONE, 0, 0, 0}, '{0, 0, 0, 0}, 1, ONE, ST_OK},
        '{OP_LENGTH,    '{CMIN, CMIN, CMIN, CMIN}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_LENGTH,    '{3, 4, 0, 0}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        // zero length on normalize: A back unchanged with the zero flag
        '{OP_NORMALIZE, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1, 0, ST_ZERO},
        '{OP_NORMALIZE, '{1, 0, 0, 0}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_NORMALIZE, '{CMIN, CMAX, -1, 1}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_NORMALIZE, '{0, 0, 0, -5}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_MATRIX,    '{ONE, 0, 0, 0}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_MATRIX,    '{CMAX, CMIN, CMAX, CMIN}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        '{OP_MATRIX,    '{ONE/2, ONE/2, -ONE/2, ONE/2}, '{0, 0, 0, 0}, 0, 0, ST_OK},
        // unused codes: a single zero word
        '{OP_UNUSED6,   '{CMAX, CMAX, CMAX, CMAX}, '{CMIN, CMIN, CMIN, CMIN}, 1, 0, ST_OK},
        '{OP_UNUSED7,   '{-1, -1, -1, -1}, '{-1, -1, -1, -1}, 1, 0, ST_OK}
    };

    initial begin
        err_cnt    = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 0;
        hold_left  = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_req_type = OP_PRODUCT;
        {i_a_w, i_a_x, i_a_y, i_a_z, i_b_w, i_b_x, i_b_y, i_b_z} = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k])
            send_req(dir_rows[k].op, dir_rows[k].a, dir_rows[k].b, dir_rows[k].typed,
                     dir_rows[k].r0, dir_rows[k].st);

        // back to back, then sender idling, receiver stalling, both
        send_random(40);
        idle_pct = 64;
        send_random(35);
        idle_pct = 0;  stall_pct = 64;
        send_random(35);
        idle_pct = 35; stall_pct = 35;
        send_random(35);

        // sender pauses until every word is out
        wait (expected_words.size() == 0);
        // long receiver hold-off while words keep coming: queue fills, o_ready drops
        idle_pct = 0; stall_pct = 0;
        @(posedge i_clk);
        hold_req = 1;
        @(negedge i_clk);
        send_random(15);

        wait (expected_words.size() == 0);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_quaternion_arithmetic_unit OK");
        else
            $display("tb_quaternion_arithmetic_unit NOT OK");
        $finish;
    end

endmodule
